[src/fzn_pkg.sv]
package fzn_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int DEV_W      = 23;
  localparam int SUM_W      = 36;
  localparam int SQ_W       = 60;
  localparam int XSQ_W      = 48;
  localparam int PROD_W     = 74;
  localparam int MR_W       = 36;
  localparam int ROOT_W     = 38;
  localparam int RAD_W      = 76;
  localparam int REM_W      = 42;
  localparam int DVD_W      = 40;
  localparam int DVS_W      = 24;
  localparam int STEP_W     = 6;
  localparam int DIMS_W     = 7;
  localparam int FLOOR_W    = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int PMAG_W     = 47;

  localparam int VAL_MAX = 8388607;
  localparam int ONE_Q12 = 4096;

  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_FINISH = 3'd1;
  localparam logic [2:0] CMD_NORM   = 3'd2;
  localparam logic [2:0] CMD_DENORM = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DIMS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 1'b1;

  typedef struct packed {
    logic [2:0]                 command;
    logic [5:0]                 dimension;
    logic signed [SAMPLE_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value_out;
    logic [DEV_W-1:0]           deviation_out;
    logic [1:0]                 status;
    logic                       last_out;
  } out_t;

  typedef enum logic [2:0] {
    SRC_OOR, SRC_FULL, SRC_EMPTY, SRC_FIN, SRC_NORM, SRC_DENORM
  } src_t;

  typedef enum logic [1:0] {
    DSEL_DEV, DSEL_MEAN, DSEL_NORM
  } dsel_t;

  typedef struct packed {
    logic  idle;
    logic  idx_item;
    logic  idx_zero;
    logic  idx_inc;
    logic  rd;
    logic  sum_wr;
    logic  clear;
    logic  mul_start;
    logic  mul_sq;
    logic  save_b;
    logic  sqrt_start;
    logic  div_start;
    dsel_t div_sel;
    logic  save_dev;
    logic  stat_wr;
    logic  dn_mul;
    logic  out_load;
    src_t  out_src;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       in_beat;
    logic [2:0] code;
    logic       oor;
    logic       full;
    logic       empty;
    logic       last_dim;
    logic       out_free;
    logic       mul_done;
    logic       sqrt_done;
    logic       div_done;
  } ctrl_stat_t;

endpackage

[src/fzn_mul.sv]
module fzn_mul import fzn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MR_W-1:0]   mr_in,
  input  logic [PROD_W-1:0] md_in,
  output logic              done,
  output logic [PROD_W-1:0] product
);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [MR_W-1:0]   mr;
  logic [PROD_W-1:0] md;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(MR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      product <= '0;
      mr      <= mr_in;
      md      <= md_in;
    end else if (busy) begin
      if (mr[0]) product <= product + md;
      md <= {md[PROD_W-2:0], 1'b0};
      mr <= {1'b0, mr[MR_W-1:1]};
    end
  end

endmodule

[src/fzn_sqrt.sv]
module fzn_sqrt import fzn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  rad_in,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  trial;
  logic              ge;

  assign shifted = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial   = {{(REM_W-ROOT_W-2){1'b0}}, root, 2'b01};
  assign ge      = shifted >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= rad_in;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= ge ? shifted - trial : shifted;
      root <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule

[src/fzn_div.sv]
module fzn_div import fzn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dvd_in,
  input  logic [DVS_W-1:0] dvs_in,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W:0]    rem;
  logic [DVS_W:0]    shifted;
  logic              ge;

  assign shifted = {rem[DVS_W-1:0], quotient[DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top while quotient bits fill in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dvd_in;
      dvs      <= dvs_in;
      rem      <= '0;
    end else if (busy) begin
      rem      <= ge ? shifted - {1'b0, dvs} : shifted;
      quotient <= {quotient[DVD_W-2:0], ge};
    end
  end

endmodule

[src/fzn_dp.sv]
module fzn_dp import fzn_pkg::*; #(
  parameter int MAX_DIMS    = 64,
  parameter int MAX_VECTORS = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  in_t                   in_data,
  input  logic                  out_stall,
  output logic                  out_valid,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctrl_cmd_t             cmd,
  output ctrl_stat_t            stat
);

  localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW = $clog2(MAX_VECTORS + 1);

  logic [DIMS_W-1:0]  dims_in_use;
  logic [FLOOR_W-1:0] std_floor;
  logic [DIMS_W-1:0]  dims;
  in_t                item;
  logic [AW-1:0]      idx;
  logic [CW-1:0]      vcount;
  logic               last_item;

  logic [SUM_W-1:0]         sum_mem  [MAX_DIMS];
  logic [SQ_W-1:0]          sq_mem   [MAX_DIMS];
  logic signed [SAMPLE_W-1:0] mean_mem [MAX_DIMS];
  logic [DEV_W-1:0]         dev_mem  [MAX_DIMS];
  logic [MAX_DIMS-1:0]      sum_vld;
  logic [MAX_DIMS-1:0]      stat_vld;

  logic [SUM_W-1:0]           rd_sum;
  logic [SQ_W-1:0]            rd_sq;
  logic signed [SAMPLE_W-1:0] rd_mean;
  logic [DEV_W-1:0]           rd_dev;
  logic                       rd_sum_v;
  logic                       rd_stat_v;

  logic [SUM_W-1:0]           sum_cur;
  logic [SQ_W-1:0]            sq_cur;
  logic signed [SAMPLE_W-1:0] mean_cur;
  logic [DEV_W-1:0]           dev_cur;

  logic [SAMPLE_W-1:0] xmag;
  logic [XSQ_W-1:0]    xsq;
  logic [SUM_W-1:0]    sum_new;
  logic [SQ_W-1:0]     sq_new;
  logic [SUM_W-1:0]    smag;

  logic [MR_W-1:0]   mr_in;
  logic [PROD_W-1:0] md_in;
  logic              mul_done;
  logic [PROD_W-1:0] product;
  logic [PROD_W-1:0] b_reg;
  logic [PROD_W-1:0] num;
  logic              sqrt_done;
  logic [ROOT_W-1:0] root;
  logic [DVD_W-1:0]  dvd_in;
  logic [DVS_W-1:0]  dvs_in;
  logic              div_done;
  logic [DVD_W-1:0]  quotient;

  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]        dmag;

  logic [DEV_W-1:0] dev_reg;
  logic             dsat_reg;
  logic [DEV_W-1:0] dev_next;
  logic             dsat_next;

  logic [SAMPLE_W:0] mean_res;
  logic [SAMPLE_W:0] norm_res;

  logic [PMAG_W-1:0]          pmag;
  logic [PMAG_W-1:0]          dn_sum;
  logic signed [37:0]         dn_s;
  logic signed [37:0]         dn_v;
  logic signed [SAMPLE_W-1:0] dn_val;
  logic                       dn_sat;

  out_t res;

  function automatic logic [SAMPLE_W:0] sat_mag(input logic neg, input logic [DVD_W-1:0] mag);
    logic [SAMPLE_W:0] r;
    if (!neg && mag > DVD_W'(VAL_MAX)) r = {1'b1, 24'h7FFFFF};
    else if (neg && mag > DVD_W'(VAL_MAX + 1)) r = {1'b1, 24'h800000};
    else if (neg) r = {1'b0, 24'(-mag[SAMPLE_W-1:0])};
    else r = {1'b0, mag[SAMPLE_W-1:0]};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= 7'd64;
      std_floor   <= 13'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIMS:  dims_in_use <= cfg_data[DIMS_W-1:0];
        REG_FLOOR: std_floor   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dims_in_use == '0) dims = 7'd1;
    else if (dims_in_use > DIMS_W'(MAX_DIMS)) dims = DIMS_W'(MAX_DIMS);
    else dims = dims_in_use;
  end

  always_ff @(posedge clk) begin
    if (cmd.idle && in_valid) item <= in_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_item) idx <= item.dimension[AW-1:0];
    else if (cmd.idx_zero) idx <= '0;
    else if (cmd.idx_inc) idx <= idx + AW'(1);
  end

  assign last_item = {1'b0, item.dimension} == dims - 7'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0;
    end else if (cmd.clear) begin
      vcount <= '0;
    end else if (cmd.sum_wr && last_item) begin
      vcount <= vcount + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_wr) begin
      sum_mem[idx] <= sum_new;
      sq_mem[idx]  <= sq_new;
    end
    if (cmd.stat_wr) begin
      mean_mem[idx] <= mean_res[SAMPLE_W-1:0];
      dev_mem[idx]  <= dev_reg;
    end
    if (cmd.rd) begin
      rd_sum  <= sum_mem[idx];
      rd_sq   <= sq_mem[idx];
      rd_mean <= mean_mem[idx];
      rd_dev  <= dev_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld   <= '0;
      stat_vld  <= '0;
      rd_sum_v  <= 1'b0;
      rd_stat_v <= 1'b0;
    end else begin
      if (cmd.clear) sum_vld <= '0;
      else if (cmd.sum_wr) sum_vld[idx] <= 1'b1;
      if (cmd.stat_wr) stat_vld[idx] <= 1'b1;
      if (cmd.rd) begin
        rd_sum_v  <= sum_vld[idx];
        rd_stat_v <= stat_vld[idx];
      end
    end
  end

  assign sum_cur  = rd_sum_v ? rd_sum : '0;
  assign sq_cur   = rd_sum_v ? rd_sq : '0;
  assign mean_cur = rd_stat_v ? rd_mean : '0;
  assign dev_cur  = rd_stat_v ? rd_dev : DEV_W'(ONE_Q12);

  assign xmag    = item.sample[SAMPLE_W-1] ? SAMPLE_W'(-item.sample) : item.sample;
  assign xsq     = xmag * xmag;
  assign sum_new = sum_cur + {{(SUM_W-SAMPLE_W){item.sample[SAMPLE_W-1]}}, item.sample};
  assign sq_new  = sq_cur + {{(SQ_W-XSQ_W){1'b0}}, xsq};
  assign smag    = sum_cur[SUM_W-1] ? SUM_W'(-sum_cur) : sum_cur;

  assign mr_in = cmd.mul_sq ? MR_W'(vcount) : smag;
  assign md_in = cmd.mul_sq ? PROD_W'(sq_cur) : PROD_W'(smag);

  fzn_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_start),
    .mr_in   (mr_in),
    .md_in   (md_in),
    .done    (mul_done),
    .product (product)
  );

  always_ff @(posedge clk) begin
    if (cmd.save_b) b_reg <= product;
  end

  assign num = (product >= b_reg) ? product - b_reg : '0;

  fzn_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.sqrt_start),
    .rad_in (RAD_W'(num)),
    .done   (sqrt_done),
    .root   (root)
  );

  assign diff = 25'(item.sample) - 25'(mean_cur);
  assign dmag = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;

  always_comb begin
    case (cmd.div_sel)
      DSEL_DEV: begin
        dvd_in = DVD_W'(root);
        dvs_in = DVS_W'(vcount);
      end
      DSEL_MEAN: begin
        dvd_in = DVD_W'(smag) + DVD_W'(vcount >> 1);
        dvs_in = DVS_W'(vcount);
      end
      DSEL_NORM: begin
        dvd_in = DVD_W'({dmag, 12'b0}) + DVD_W'(dev_cur >> 1);
        dvs_in = DVS_W'(dev_cur);
      end
      default: begin
        dvd_in = '0;
        dvs_in = DVS_W'(1);
      end
    endcase
  end

  fzn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dvd_in   (dvd_in),
    .dvs_in   (dvs_in),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    dsat_next = 1'b0;
    if (quotient > DVD_W'(VAL_MAX)) begin
      dev_next  = DEV_W'(VAL_MAX);
      dsat_next = 1'b1;
    end else begin
      dev_next = quotient[DEV_W-1:0];
    end
    if (dev_next == '0 || dev_next < DEV_W'(std_floor)) dev_next = DEV_W'(ONE_Q12);
  end

  always_ff @(posedge clk) begin
    if (cmd.save_dev) begin
      dev_reg  <= dev_next;
      dsat_reg <= dsat_next;
    end
  end

  assign mean_res = sat_mag(sum_cur[SUM_W-1], quotient);
  assign norm_res = sat_mag(diff[SAMPLE_W], quotient);

  always_ff @(posedge clk) begin
    if (cmd.dn_mul) pmag <= PMAG_W'(xmag * dev_cur);
  end

  assign dn_sum = pmag + PMAG_W'(2048);
  assign dn_s   = item.sample[SAMPLE_W-1] ? -$signed({3'b0, dn_sum[PMAG_W-1:12]})
                                          : $signed({3'b0, dn_sum[PMAG_W-1:12]});
  assign dn_v   = dn_s + 38'(mean_cur);

  always_comb begin
    dn_sat = 1'b0;
    dn_val = dn_v[SAMPLE_W-1:0];
    if (dn_v > 38'sd8388607) begin
      dn_sat = 1'b1;
      dn_val = 24'sh7FFFFF;
    end else if (dn_v < -38'sd8388608) begin
      dn_sat = 1'b1;
      dn_val = 24'sh800000;
    end
  end

  always_comb begin
    res          = '0;
    res.last_out = 1'b1;
    case (cmd.out_src)
      SRC_OOR:   res.status = ST_RANGE;
      SRC_FULL:  res.status = ST_SAT;
      SRC_EMPTY: res.status = ST_EMPTY;
      SRC_FIN: begin
        res.value_out     = mean_res[SAMPLE_W-1:0];
        res.deviation_out = dev_reg;
        res.status        = (dsat_reg || mean_res[SAMPLE_W]) ? ST_SAT : ST_OK;
        res.last_out      = stat.last_dim;
      end
      SRC_NORM: begin
        res.value_out = norm_res[SAMPLE_W-1:0];
        res.status    = norm_res[SAMPLE_W] ? ST_SAT : ST_OK;
      end
      SRC_DENORM: begin
        res.value_out = dn_val;
        res.status    = dn_sat ? ST_SAT : ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= res;
  end

  assign stat.in_beat   = in_valid;
  assign stat.code      = item.command;
  assign stat.oor       = {1'b0, item.dimension} >= dims;
  assign stat.full      = vcount >= CW'(MAX_VECTORS);
  assign stat.empty     = vcount == '0;
  assign stat.last_dim  = DIMS_W'(idx) == dims - 7'd1;
  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.mul_done  = mul_done;
  assign stat.sqrt_done = sqrt_done;
  assign stat.div_done  = div_done;

endmodule

[src/fzn_ctrl.sv]
module fzn_ctrl import fzn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd,
  output logic       in_stall
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_DEC   = 19'h00002,
    S_RD    = 19'h00004,
    S_LWR   = 19'h00008,
    S_MB_GO = 19'h00010,
    S_MB_W  = 19'h00020,
    S_MA_GO = 19'h00040,
    S_MA_W  = 19'h00080,
    S_SQ_GO = 19'h00100,
    S_SQ_W  = 19'h00200,
    S_DV_GO = 19'h00400,
    S_DV_W  = 19'h00800,
    S_MN_GO = 19'h01000,
    S_MN_W  = 19'h02000,
    S_FE    = 19'h04000,
    S_ND_GO = 19'h08000,
    S_ND_W  = 19'h10000,
    S_DN    = 19'h20000,
    S_EMIT  = 19'h40000
  } state_t;

  state_t state;
  state_t state_next;
  src_t   emit_src;
  src_t   emit_src_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      emit_src <= SRC_OOR;
    end else begin
      state    <= state_next;
      emit_src <= emit_src_next;
    end
  end

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next    = state;
    emit_src_next = emit_src;
    cmd           = '0;
    cmd.out_src   = emit_src;
    cmd.idle      = state == S_IDLE;
    case (state)
      S_IDLE: begin
        if (stat.in_beat) state_next = S_DEC;
      end
      S_DEC: begin
        case (stat.code)
          CMD_LOAD: begin
            if (stat.oor) begin
              emit_src_next = SRC_OOR;
              state_next    = S_EMIT;
            end else if (stat.full) begin
              emit_src_next = SRC_FULL;
              state_next    = S_EMIT;
            end else begin
              cmd.idx_item = 1'b1;
              state_next   = S_RD;
            end
          end
          CMD_FINISH: begin
            if (stat.empty) begin
              emit_src_next = SRC_EMPTY;
              state_next    = S_EMIT;
            end else begin
              cmd.idx_zero = 1'b1;
              state_next   = S_RD;
            end
          end
          CMD_NORM, CMD_DENORM: begin
            if (stat.oor) begin
              emit_src_next = SRC_OOR;
              state_next    = S_EMIT;
            end else begin
              cmd.idx_item = 1'b1;
              state_next   = S_RD;
            end
          end
          CMD_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_RD: begin
        cmd.rd = 1'b1;
        case (stat.code)
          CMD_LOAD:   state_next = S_LWR;
          CMD_FINISH: state_next = S_MB_GO;
          CMD_NORM:   state_next = S_ND_GO;
          CMD_DENORM: state_next = S_DN;
          default:    state_next = S_IDLE;
        endcase
      end
      S_LWR: begin
        cmd.sum_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_MB_GO: begin
        cmd.mul_start = 1'b1;
        state_next    = S_MB_W;
      end
      S_MB_W: begin
        if (stat.mul_done) begin
          cmd.save_b = 1'b1;
          state_next = S_MA_GO;
        end
      end
      S_MA_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sq    = 1'b1;
        state_next    = S_MA_W;
      end
      S_MA_W: begin
        if (stat.mul_done) state_next = S_SQ_GO;
      end
      S_SQ_GO: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SQ_W;
      end
      S_SQ_W: begin
        if (stat.sqrt_done) state_next = S_DV_GO;
      end
      S_DV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_DEV;
        state_next    = S_DV_W;
      end
      S_DV_W: begin
        if (stat.div_done) begin
          cmd.save_dev = 1'b1;
          state_next   = S_MN_GO;
        end
      end
      S_MN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_MEAN;
        state_next    = S_MN_W;
      end
      S_MN_W: begin
        if (stat.div_done) state_next = S_FE;
      end
      S_FE: begin
        cmd.out_src = SRC_FIN;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.stat_wr  = 1'b1;
          if (stat.last_dim) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_RD;
          end
        end
      end
      S_ND_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_NORM;
        state_next    = S_ND_W;
      end
      S_ND_W: begin
        cmd.div_sel = DSEL_NORM;
        if (stat.div_done) begin
          emit_src_next = SRC_NORM;
          state_next    = S_EMIT;
        end
      end
      S_DN: begin
        cmd.dn_mul    = 1'b1;
        emit_src_next = SRC_DENORM;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[src/feature_zscore_normalizer.sv]
// Per-dimension z-score statistics and element normalisation, signed Q11.12.
// Input channel (in_valid/in_stall/in_data) carries one command beat: load an
// element into the sums, finish the statistics, normalise or denormalise one
// element, or clear the sums. Output channel (out_valid/out_stall/out_data)
// carries result beats; last_out marks the final beat of a command.
// One command is in flight at a time; in_stall is high until it completes.
// Load reads the stored sums and writes them back. Normalise uses the 40-step
// shared divider; denormalise uses one registered multiply. Finish runs once
// per dimension in use: a 36-step serial multiplier run twice, a 38-step
// square root and two 40-step divisions. The user writes configuration
// (cfg_we/cfg_index/cfg_data) only while the block is idle; it is not enforced.
// Reset clears the sums and the vector count, sets every stored mean to zero
// and every deviation to 1.0, dims_in_use to 64 and std_floor to 1.
// A stalled result beat holds in the output register; the controller waits
// for it to drain before it loads the next one, so no beat is lost.
module feature_zscore_normalizer import fzn_pkg::*; #(
  parameter int MAX_DIMS    = 64,
  parameter int MAX_VECTORS = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  fzn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  fzn_dp #(
    .MAX_DIMS    (MAX_DIMS),
    .MAX_VECTORS (MAX_VECTORS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
